@@ design/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg: shared types and codes for the rational arithmetic unit
// Command codes, order codes, controller states, datapath ops and status.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_DIV = 2'd3;

   localparam logic [1:0] ORDER_EQUAL   = 2'd0;
   localparam logic [1:0] ORDER_LESS    = 2'd1;
   localparam logic [1:0] ORDER_GREATER = 2'd2;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL_LHS,
      OP_MUL_RHS,
      OP_ORDER,
      OP_GCD_DEN,
      OP_RED_INIT,
      OP_GCD_STEP,
      OP_GCD_FIN,
      OP_DIV_D2,
      OP_DIV_D1,
      OP_DIV_MN,
      OP_DIV_MD,
      OP_DIV_STEP,
      OP_KEEP_Q1,
      OP_KEEP_Q2,
      OP_MUL_T1,
      OP_MUL_T2,
      OP_SUM,
      OP_MUL_LD,
      OP_MUL_NN,
      OP_MUL_DD,
      OP_DIV_SET,
      OP_OUT
   } dp_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_L,
      ST_MUL_R,
      ST_ORDER,
      ST_BRANCH,
      ST_GCD_DEN,
      ST_GCD1,
      ST_DQ1,
      ST_DQ1_RUN,
      ST_DQ2,
      ST_DQ2_RUN,
      ST_T1,
      ST_T2,
      ST_SUM,
      ST_LCM,
      ST_MUL_NN,
      ST_MUL_DD,
      ST_DIV_SET,
      ST_RED,
      ST_RED_CHK,
      ST_GCD2,
      ST_DN,
      ST_DN_RUN,
      ST_DD,
      ST_DD_RUN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       err;
      logic [1:0] cmd;
      logic       num_zero;
      logic       gcd_done;
      logic       div_done;
   } dp_status_type;

endpackage

@@ design/rau_datapath.sv @@
// ----------------------------------------------------------------------------
// rau_datapath: operand registers, shared multiplier, GCD and divider
// Executes one op per cycle as selected by the controller.
// ----------------------------------------------------------------------------
module rau_datapath #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                        clock,
   input  rau_pkg::dp_op_type          op,
   input  logic [1:0]                  req_command,
   input  logic signed [OPERAND_WIDTH-1:0] req_first_num,
   input  logic [OPERAND_WIDTH-2:0]    req_first_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_second_num,
   input  logic [OPERAND_WIDTH-2:0]    req_second_den,
   output rau_pkg::dp_status_type      status,
   output logic signed [31:0]          rsp_result_num,
   output logic [29:0]                 rsp_result_den,
   output logic [1:0]                  rsp_order,
   output logic                        rsp_error_code
);
   import rau_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int DW = W - 1;
   localparam int WW = 2 * W + 2;
   localparam int CW = $clog2(WW + 1);
   localparam int WX = (WW > 32) ? WW : 32;

   logic [1:0]          cmd_ff, cmd_in;
   logic signed [W-1:0] n1_ff, n1_in, n2_ff, n2_in;
   logic [DW-1:0]       d1_ff, d1_in, d2_ff, d2_in;
   logic signed [WW-1:0] plhs_ff, plhs_in, prhs_ff, prhs_in;
   logic signed [WW-1:0] num_ff, num_in, den_ff, den_in;
   logic [WW-1:0]       q1_ff, q1_in, q2_ff, q2_in;
   logic [WW-1:0]       a_ff, a_in, b_ff, b_in, g_ff, g_in;
   logic [CW-1:0]       k_ff, k_in, cnt_ff, cnt_in;
   logic [WW-1:0]       rem_ff, rem_in, dvd_ff, dvd_in, quo_ff, quo_in;
   logic [1:0]          ord_ff, ord_in;
   logic                err_ff, err_in, neg_ff, neg_in;
   logic signed [31:0]  onum_ff, onum_in;
   logic [29:0]         oden_ff, oden_in;
   logic [1:0]          oord_ff, oord_in;
   logic                oerr_ff, oerr_in;

   logic signed [W:0]    mul_a, mul_b;
   logic signed [WW-1:0] mul_p;
   logic [WW-1:0]        mag_num, mag_den;
   logic [WW:0]          trial;
   logic signed [WX-1:0] qx;

   assign mag_num = num_ff[WW-1] ? WW'(-num_ff) : WW'(num_ff);
   assign mag_den = den_ff[WW-1] ? WW'(-den_ff) : WW'(den_ff);
   assign trial   = {rem_ff, dvd_ff[WW-1]};
   assign qx      = WX'(q1_ff);

   // shared multiplier operand select
   always_comb begin
      case (op)
         OP_MUL_LHS: begin
            mul_a = {n1_ff[W-1], n1_ff};
            mul_b = signed'({2'b00, d2_ff});
         end
         OP_MUL_RHS: begin
            mul_a = {n2_ff[W-1], n2_ff};
            mul_b = signed'({2'b00, d1_ff});
         end
         OP_MUL_T1: begin
            mul_a = signed'({2'b00, q1_ff[DW-1:0]});
            mul_b = {n1_ff[W-1], n1_ff};
         end
         OP_MUL_T2: begin
            mul_a = signed'({2'b00, q2_ff[DW-1:0]});
            mul_b = {n2_ff[W-1], n2_ff};
         end
         OP_MUL_LD: begin
            mul_a = signed'({2'b00, q2_ff[DW-1:0]});
            mul_b = signed'({2'b00, d2_ff});
         end
         OP_MUL_NN: begin
            mul_a = {n1_ff[W-1], n1_ff};
            mul_b = {n2_ff[W-1], n2_ff};
         end
         OP_MUL_DD: begin
            mul_a = signed'({2'b00, d1_ff});
            mul_b = signed'({2'b00, d2_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      cmd_in  = cmd_ff;
      n1_in   = n1_ff;
      n2_in   = n2_ff;
      d1_in   = d1_ff;
      d2_in   = d2_ff;
      plhs_in = plhs_ff;
      prhs_in = prhs_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      q1_in   = q1_ff;
      q2_in   = q2_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      g_in    = g_ff;
      k_in    = k_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      ord_in  = ord_ff;
      err_in  = err_ff;
      neg_in  = neg_ff;
      onum_in = onum_ff;
      oden_in = oden_ff;
      oord_in = oord_ff;
      oerr_in = oerr_ff;
      case (op)
         OP_LOAD: begin
            cmd_in = req_command;
            n1_in  = req_first_num;
            d1_in  = req_first_den;
            n2_in  = req_second_num;
            d2_in  = req_second_den;
         end
         OP_MUL_LHS: plhs_in = mul_p;
         OP_MUL_RHS: prhs_in = mul_p;
         OP_ORDER: begin
            if (plhs_ff == prhs_ff) begin
               ord_in = ORDER_EQUAL;
            end else if (plhs_ff < prhs_ff) begin
               ord_in = ORDER_LESS;
            end else begin
               ord_in = ORDER_GREATER;
            end
            err_in = (d1_ff == '0) || (d2_ff == '0) ||
                     ((cmd_ff == CMD_DIV) && (n2_ff == '0));
         end
         OP_GCD_DEN: begin
            a_in = WW'(d1_ff);
            b_in = WW'(d2_ff);
            k_in = '0;
         end
         OP_RED_INIT: begin
            a_in   = mag_num;
            b_in   = mag_den;
            k_in   = '0;
            neg_in = num_ff[WW-1] ^ den_ff[WW-1];
         end
         OP_GCD_STEP: begin
            // binary GCD: strip common twos, then subtract odd from odd
            if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff >= b_ff) begin
               a_in = (a_ff - b_ff) >> 1;
            end else begin
               b_in = (b_ff - a_ff) >> 1;
            end
         end
         OP_GCD_FIN: g_in = (a_ff | b_ff) << k_ff;
         OP_DIV_D2, OP_DIV_D1, OP_DIV_MN, OP_DIV_MD: begin
            rem_in = '0;
            quo_in = '0;
            cnt_in = '0;
            case (op)
               OP_DIV_D2: dvd_in = WW'(d2_ff);
               OP_DIV_D1: dvd_in = WW'(d1_ff);
               OP_DIV_MN: dvd_in = mag_num;
               default:   dvd_in = mag_den;
            endcase
         end
         OP_DIV_STEP: begin
            // restoring divide, one quotient bit per cycle
            if (trial >= {1'b0, g_ff}) begin
               rem_in = WW'(trial - {1'b0, g_ff});
               quo_in = {quo_ff[WW-2:0], 1'b1};
            end else begin
               rem_in = trial[WW-1:0];
               quo_in = {quo_ff[WW-2:0], 1'b0};
            end
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 1'b1;
         end
         OP_KEEP_Q1: q1_in = quo_ff;
         OP_KEEP_Q2: q2_in = quo_ff;
         OP_MUL_T1: num_in = mul_p;
         OP_MUL_T2: prhs_in = mul_p;
         OP_SUM: num_in = (cmd_ff == CMD_SUB) ? num_ff - prhs_ff : num_ff + prhs_ff;
         OP_MUL_LD: den_in = mul_p;
         OP_MUL_NN: num_in = mul_p;
         OP_MUL_DD: den_in = mul_p;
         OP_DIV_SET: begin
            num_in = plhs_ff;
            den_in = prhs_ff;
         end
         OP_OUT: begin
            oord_in = ord_ff;
            oerr_in = err_ff;
            if (err_ff || (num_ff == '0)) begin
               onum_in = '0;
               oden_in = 30'd1;
            end else begin
               onum_in = neg_ff ? 32'(-qx) : 32'(qx);
               oden_in = 30'(WX'(q2_ff));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      n1_ff   <= n1_in;
      n2_ff   <= n2_in;
      d1_ff   <= d1_in;
      d2_ff   <= d2_in;
      plhs_ff <= plhs_in;
      prhs_ff <= prhs_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      q1_ff   <= q1_in;
      q2_ff   <= q2_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      g_ff    <= g_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      ord_ff  <= ord_in;
      err_ff  <= err_in;
      neg_ff  <= neg_in;
      onum_ff <= onum_in;
      oden_ff <= oden_in;
      oord_ff <= oord_in;
      oerr_ff <= oerr_in;
   end

   assign status.err      = err_ff;
   assign status.cmd      = cmd_ff;
   assign status.num_zero = (num_ff == '0);
   assign status.gcd_done = (a_ff == '0) || (b_ff == '0);
   assign status.div_done = (cnt_ff == CW'(WW));

   assign rsp_result_num = onum_ff;
   assign rsp_result_den = oden_ff;
   assign rsp_order      = oord_ff;
   assign rsp_error_code = oerr_ff;

endmodule

@@ design/rau_controller.sv @@
// ----------------------------------------------------------------------------
// rau_controller: sequencer for the rational arithmetic unit
// Steps the datapath through each command and owns both handshakes.
// ----------------------------------------------------------------------------
module rau_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rau_pkg::dp_status_type status,
   output rau_pkg::dp_op_type     op
);
   import rau_pkg::*;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      out_free;

   assign out_free = !valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_MUL_L;
         ST_MUL_L:   state_in = ST_MUL_R;
         ST_MUL_R:   state_in = ST_ORDER;
         ST_ORDER:   state_in = ST_BRANCH;
         ST_BRANCH: begin
            if (status.err) begin
               state_in = ST_OUT;
            end else begin
               case (status.cmd)
                  CMD_MUL: state_in = ST_MUL_NN;
                  CMD_DIV: state_in = ST_DIV_SET;
                  default: state_in = ST_GCD_DEN;
               endcase
            end
         end
         ST_GCD_DEN: state_in = ST_GCD1;
         ST_GCD1:    if (status.gcd_done) state_in = ST_DQ1;
         ST_DQ1:     state_in = ST_DQ1_RUN;
         ST_DQ1_RUN: if (status.div_done) state_in = ST_DQ2;
         ST_DQ2:     state_in = ST_DQ2_RUN;
         ST_DQ2_RUN: if (status.div_done) state_in = ST_T1;
         ST_T1:      state_in = ST_T2;
         ST_T2:      state_in = ST_SUM;
         ST_SUM:     state_in = ST_LCM;
         ST_LCM:     state_in = ST_RED;
         ST_MUL_NN:  state_in = ST_MUL_DD;
         ST_MUL_DD:  state_in = ST_RED;
         ST_DIV_SET: state_in = ST_RED;
         ST_RED:     state_in = ST_RED_CHK;
         ST_RED_CHK: state_in = status.num_zero ? ST_OUT : ST_GCD2;
         ST_GCD2:    if (status.gcd_done) state_in = ST_DN;
         ST_DN:      state_in = ST_DN_RUN;
         ST_DN_RUN:  if (status.div_done) state_in = ST_DD;
         ST_DD:      state_in = ST_DD_RUN;
         ST_DD_RUN:  if (status.div_done) state_in = ST_OUT;
         ST_OUT:     if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      op       = OP_NOP;
      valid_in = valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE:    if (req_valid) op = OP_LOAD;
         ST_MUL_L:   op = OP_MUL_LHS;
         ST_MUL_R:   op = OP_MUL_RHS;
         ST_ORDER:   op = OP_ORDER;
         ST_GCD_DEN: op = OP_GCD_DEN;
         ST_GCD1:    op = status.gcd_done ? OP_GCD_FIN : OP_GCD_STEP;
         ST_DQ1:     op = OP_DIV_D2;
         ST_DQ1_RUN: op = status.div_done ? OP_KEEP_Q1 : OP_DIV_STEP;
         ST_DQ2:     op = OP_DIV_D1;
         ST_DQ2_RUN: op = status.div_done ? OP_KEEP_Q2 : OP_DIV_STEP;
         ST_T1:      op = OP_MUL_T1;
         ST_T2:      op = OP_MUL_T2;
         ST_SUM:     op = OP_SUM;
         ST_LCM:     op = OP_MUL_LD;
         ST_MUL_NN:  op = OP_MUL_NN;
         ST_MUL_DD:  op = OP_MUL_DD;
         ST_DIV_SET: op = OP_DIV_SET;
         ST_RED:     op = OP_RED_INIT;
         ST_GCD2:    op = status.gcd_done ? OP_GCD_FIN : OP_GCD_STEP;
         ST_DN:      op = OP_DIV_MN;
         ST_DN_RUN:  op = status.div_done ? OP_KEEP_Q1 : OP_DIV_STEP;
         ST_DD:      op = OP_DIV_MD;
         ST_DD_RUN:  op = status.div_done ? OP_KEEP_Q2 : OP_DIV_STEP;
         ST_OUT: begin
            if (out_free) begin
               op       = OP_OUT;
               valid_in = 1'b1;
            end
         end
         default:    op = OP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

@@ design/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: add, subtract, multiply, divide two fractions
// Results are reduced by the GCD; operand order is reported on every beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel: one beat carries a command and two fractions. A beat is
//   taken when req_valid is high and req_stall is low; req_stall is high
//   while an item is in work, so one item is in flight at a time.
//   rsp_* channel: one result beat per request, held in an output register.
//   The next request is accepted while a finished result still waits.
// Work per item:
//   The divider is bit-serial and the GCD is an iterative binary loop.
//   Add/subtract needs two GCDs and four quotients, multiply/divide one
//   GCD and two. An error beat (zero denominator, divide by zero) skips
//   all of them; a zero product or quotient skips the GCD and divides.
//   A zero sum or difference still runs the denominator steps.
// Reset: synchronous, active high; clears the sequencer and rsp_valid.
// Stall: if rsp_stall holds the last result, the sequencer waits in its
//   output step and the held beat stays unchanged.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_command,
   input  logic signed [OPERAND_WIDTH-1:0] req_first_num,
   input  logic [OPERAND_WIDTH-2:0]        req_first_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_second_num,
   input  logic [OPERAND_WIDTH-2:0]        req_second_den,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [31:0]              rsp_result_num,
   output logic [29:0]                     rsp_result_den,
   output logic [1:0]                      rsp_order,
   output logic                            rsp_error_code
);
   import rau_pkg::*;

   dp_op_type     op;
   dp_status_type status;

   // sequencer: one datapath op per cycle
   rau_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .op        (op)
   );

   // multiplier, GCD, divider and output register
   rau_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dp (
      .clock          (clock),
      .op             (op),
      .req_command    (req_command),
      .req_first_num  (req_first_num),
      .req_first_den  (req_first_den),
      .req_second_num (req_second_num),
      .req_second_den (req_second_den),
      .status         (status),
      .rsp_result_num (rsp_result_num),
      .rsp_result_den (rsp_result_den),
      .rsp_order      (rsp_order),
      .rsp_error_code (rsp_error_code)
   );

endmodule
